### src/bcc_pkg.sv
// shared types and constants for the button click classifier
`default_nettype none
package bcc_pkg;

    localparam int unsigned DEB_W       = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [DEB_W-1:0]      DEB_RESET    = 8'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_RESET   = 16'd4000;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_RESET = 16'd350;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_DOUBLE   = 2'd2
    } bcc_reg_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } bcc_event_t;

    typedef struct packed {
        bcc_event_t click_event;
        logic       stable_level;
    } bcc_result_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } bcc_cfg_wr_t;

endpackage
`default_nettype wire

### src/bcc_ifs.sv
// handshake channel interfaces for ticks, results and register writes
`default_nettype none
interface bcc_tick_if;
    logic valid;
    logic ready;
    logic button_level;
    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface bcc_click_if;
    logic       valid;
    logic       ready;
    logic [1:0] click_event;
    logic       stable_level;
    modport source (output valid, output click_event, output stable_level, input ready);
    modport sink (input valid, input click_event, input stable_level, output ready);
endinterface

interface bcc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bcc_pkg::CFG_INDEX_W-1:0]   index;
    logic [bcc_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/bcc_core.sv
// front part: register file, debounce and hold/window timers, one tick per cycle while take is high
`default_nettype none
module bcc_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bcc_pkg::bcc_cfg_wr_t cfg_wr,
    input  wire logic                 take,
    input  wire logic                 level,
    output bcc_pkg::bcc_result_t      result
);

    localparam int unsigned CMP_W = (TIMER_WIDTH > bcc_pkg::CFG_DATA_W) ?
                                    TIMER_WIDTH : bcc_pkg::CFG_DATA_W;
    localparam logic [CMP_W-1:0] TMAX = CMP_W'((64'd1 << TIMER_WIDTH) - 64'd1);

    logic [bcc_pkg::DEB_W-1:0]      deb_ticks_reg;
    logic [bcc_pkg::CFG_DATA_W-1:0] long_ticks_reg;
    logic [bcc_pkg::CFG_DATA_W-1:0] double_ticks_reg;

    logic                      raw_prev_reg, raw_prev_next;
    logic [bcc_pkg::DEB_W-1:0] deb_rem_reg, deb_rem_next;
    logic                      deb_run_reg, deb_run_next;
    logic                      stable_reg, stable_next;
    logic [TIMER_WIDTH-1:0]    hold_rem_reg, hold_rem_next;
    logic                      hold_run_reg, hold_run_next;
    logic                      long_rep_reg, long_rep_next;
    logic [TIMER_WIDTH-1:0]    win_rem_reg, win_rem_next;
    logic                      dbl_pend_reg, dbl_pend_next;
    bcc_pkg::bcc_event_t       event_next;

    function automatic logic [TIMER_WIDTH-1:0] timer_load(
        input logic [bcc_pkg::CFG_DATA_W-1:0] r
    );
        logic [CMP_W-1:0] v;
        v = CMP_W'(r);
        if (r == '0)
            v = CMP_W'(1);
        if (v > TMAX)
            v = TMAX;
        return TIMER_WIDTH'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ticks_reg    <= bcc_pkg::DEB_RESET;
            long_ticks_reg   <= bcc_pkg::LONG_RESET;
            double_ticks_reg <= bcc_pkg::DOUBLE_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                bcc_pkg::REG_DEBOUNCE: deb_ticks_reg    <= cfg_wr.data[bcc_pkg::DEB_W-1:0];
                bcc_pkg::REG_LONG:     long_ticks_reg   <= cfg_wr.data;
                bcc_pkg::REG_DOUBLE:   double_ticks_reg <= cfg_wr.data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        raw_prev_next = raw_prev_reg;
        deb_rem_next  = deb_rem_reg;
        deb_run_next  = deb_run_reg;
        stable_next   = stable_reg;
        hold_rem_next = hold_rem_reg;
        hold_run_next = hold_run_reg;
        long_rep_next = long_rep_reg;
        win_rem_next  = win_rem_reg;
        dbl_pend_next = dbl_pend_reg;
        event_next    = bcc_pkg::EV_NONE;

        // hold timer
        if (hold_run_reg)
        begin
            if (hold_rem_next != '0)
                hold_rem_next = hold_rem_next - TIMER_WIDTH'(1);
            if (hold_rem_next == '0)
            begin
                hold_run_next = 1'b0;
                if (stable_reg)
                begin
                    long_rep_next = 1'b1;
                    dbl_pend_next = 1'b0;
                    win_rem_next  = '0;
                    event_next    = bcc_pkg::EV_LONG;
                end
            end
        end

        // double-click window
        if (dbl_pend_next)
        begin
            if (win_rem_next != '0)
                win_rem_next = win_rem_next - TIMER_WIDTH'(1);
            if (win_rem_next == '0)
                dbl_pend_next = 1'b0;
        end

        // debounce
        if (level != raw_prev_reg)
        begin
            raw_prev_next = level;
            deb_rem_next  = (deb_ticks_reg == '0) ? bcc_pkg::DEB_W'(1) : deb_ticks_reg;
            deb_run_next  = 1'b1;
        end
        else if (deb_run_reg)
        begin
            if (deb_rem_next != '0)
                deb_rem_next = deb_rem_next - bcc_pkg::DEB_W'(1);
            if (deb_rem_next == '0)
            begin
                deb_run_next = 1'b0;
                if (level != stable_reg)
                begin
                    stable_next = level;
                    if (level)
                    begin
                        hold_rem_next = timer_load(long_ticks_reg);
                        hold_run_next = 1'b1;
                        long_rep_next = 1'b0;
                    end
                    else if (!long_rep_next)
                    begin
                        hold_run_next = 1'b0;
                        hold_rem_next = '0;
                        if (!dbl_pend_next)
                        begin
                            dbl_pend_next = 1'b1;
                            win_rem_next  = timer_load(double_ticks_reg);
                            event_next    = bcc_pkg::EV_SINGLE;
                        end
                        else
                        begin
                            dbl_pend_next = 1'b0;
                            win_rem_next  = '0;
                            event_next    = bcc_pkg::EV_DOUBLE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= 1'b0;
            deb_rem_reg  <= '0;
            deb_run_reg  <= 1'b0;
            stable_reg   <= 1'b0;
            hold_rem_reg <= '0;
            hold_run_reg <= 1'b0;
            long_rep_reg <= 1'b0;
            win_rem_reg  <= '0;
            dbl_pend_reg <= 1'b0;
        end
        else if (take)
        begin
            raw_prev_reg <= raw_prev_next;
            deb_rem_reg  <= deb_rem_next;
            deb_run_reg  <= deb_run_next;
            stable_reg   <= stable_next;
            hold_rem_reg <= hold_rem_next;
            hold_run_reg <= hold_run_next;
            long_rep_reg <= long_rep_next;
            win_rem_reg  <= win_rem_next;
            dbl_pend_reg <= dbl_pend_next;
        end
    end

    assign result.click_event  = event_next;
    assign result.stable_level = stable_next;

    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !dbl_pend_reg |-> win_rem_reg == '0)
        else $error("window count left over with no pending double click");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_run_reg |-> hold_rem_reg == '0)
        else $error("hold count left over with hold timer stopped");

    a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        take && event_next == bcc_pkg::EV_LONG |-> stable_reg)
        else $error("long click reported while released");

    a_click_released: assert property (@(posedge clk) disable iff (!rst_n)
        take && (event_next == bcc_pkg::EV_SINGLE || event_next == bcc_pkg::EV_DOUBLE)
        |=> !stable_reg)
        else $error("single or double click reported while pressed");

endmodule
`default_nettype wire

### src/bcc_queue.sv
// back part: short result queue feeding the output channel
`default_nettype none
module bcc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bcc_pkg::bcc_result_t push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bcc_pkg::bcc_result_t      out_data
);

    localparam int unsigned PTR_W = $clog2(bcc_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(bcc_pkg::QUEUE_DEPTH + 1);

    bcc_pkg::bcc_result_t mem [bcc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign full      = (cnt_reg == CNT_W'(bcc_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bcc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bcc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(bcc_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

### src/button_click_classifier_unit.sv
// Button click classifier: takes one raw button level per tick request and returns one
// result request per tick (click_event, stable_level). The front core does a tick's whole
// debounce, hold-timer and window-timer update combinationally, so a tick can be taken
// every cycle while the queue has room; its result enters a two-entry queue that feeds the
// output. tick_in.ready drops only while that queue is full, i.e. while the output side
// stalls. Register writes are always taken (cfg.ready is tied high) and apply from the next
// tick on. TIMER_WIDTH sets the hold and window counter width; longer settings saturate.
`default_nettype none
module button_click_classifier_unit #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bcc_cfg_if.sink    cfg,
    bcc_tick_if.sink   tick_in,
    bcc_click_if.source click_out
);

    bcc_pkg::bcc_cfg_wr_t cfg_wr;
    bcc_pkg::bcc_result_t core_result;
    bcc_pkg::bcc_result_t q_data;
    logic                 q_full;
    logic                 take;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign tick_in.ready = !q_full;
    assign take          = tick_in.valid && !q_full;

    bcc_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .take   (take),
        .level  (tick_in.button_level),
        .result (core_result)
    );

    bcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .full      (q_full),
        .out_valid (click_out.valid),
        .out_ready (click_out.ready),
        .out_data  (q_data)
    );

    assign click_out.click_event  = q_data.click_event;
    assign click_out.stable_level = q_data.stable_level;

endmodule
`default_nettype wire

### verif/button_click_classifier_unit_test.sv
// self-checking testbench for the button click classifier: directed and random clicks
module button_click_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TIMER_W = 16;
    localparam logic [bcc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    bcc_cfg_if   cfg_bus ();
    bcc_tick_if  tick_bus ();
    bcc_click_if click_bus ();

    button_click_classifier_unit #(
        .TIMER_WIDTH(TIMER_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .tick_in   (tick_bus),
        .click_out (click_bus)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // classifier state mirrored at the block's widths
    logic [bcc_pkg::DEB_W-1:0]      set_debounce = bcc_pkg::DEB_RESET;
    logic [bcc_pkg::CFG_DATA_W-1:0] set_long     = bcc_pkg::LONG_RESET;
    logic [bcc_pkg::CFG_DATA_W-1:0] set_double   = bcc_pkg::DOUBLE_RESET;
    logic                           raw_last     = 1'b0;
    logic [bcc_pkg::DEB_W-1:0]      settle_left  = '0;
    logic                           settling     = 1'b0;
    logic                           level_now    = 1'b0;
    logic [TIMER_W-1:0]             hold_left    = '0;
    logic                           holding      = 1'b0;
    logic                           long_done    = 1'b0;
    logic [TIMER_W-1:0]             window_left  = '0;
    logic                           window_open  = 1'b0;

    bcc_pkg::bcc_result_t pending_results[$];

    int unsigned errors        = 0;
    int unsigned ticks_sent    = 0;
    int unsigned writes_done   = 0;
    int unsigned results_seen  = 0;
    int unsigned click_count[4] = '{0, 0, 0, 0};
    bit          tick_idle     = 1'b1;
    bit          sink_idle     = 1'b1;

    function automatic int unsigned idle_draw(input bit on);
        return on ? $urandom_range(16, 0) : 0;
    endfunction

    function automatic logic [TIMER_W-1:0] timer_start(
        input logic [bcc_pkg::CFG_DATA_W-1:0] setting
    );
        longint unsigned limit;
        longint unsigned v;
        limit = (64'd1 << TIMER_W) - 1;
        v = (setting == '0) ? 1 : setting;
        if (v > limit)
            v = limit;
        return v[TIMER_W-1:0];
    endfunction

    function automatic bcc_pkg::bcc_result_t classify_tick(input logic level);
        bcc_pkg::bcc_event_t  click;
        bcc_pkg::bcc_result_t res;
        click = bcc_pkg::EV_NONE;
        if (holding)
        begin
            if (hold_left != '0)
                hold_left--;
            if (hold_left == '0)
            begin
                holding = 1'b0;
                if (level_now)
                begin
                    long_done   = 1'b1;
                    window_open = 1'b0;
                    window_left = '0;
                    click       = bcc_pkg::EV_LONG;
                end
            end
        end
        if (window_open)
        begin
            if (window_left != '0)
                window_left--;
            if (window_left == '0)
                window_open = 1'b0;
        end
        if (level != raw_last)
        begin
            raw_last    = level;
            settle_left = (set_debounce == '0) ? bcc_pkg::DEB_W'(1) : set_debounce;
            settling    = 1'b1;
        end
        else if (settling)
        begin
            if (settle_left != '0)
                settle_left--;
            if (settle_left == '0)
            begin
                settling = 1'b0;
                if (level != level_now)
                begin
                    level_now = level;
                    if (level)
                    begin
                        hold_left = timer_start(set_long);
                        holding   = 1'b1;
                        long_done = 1'b0;
                    end
                    else if (!long_done)
                    begin
                        holding   = 1'b0;
                        hold_left = '0;
                        if (!window_open)
                        begin
                            window_open = 1'b1;
                            window_left = timer_start(set_double);
                            click       = bcc_pkg::EV_SINGLE;
                        end
                        else
                        begin
                            window_open = 1'b0;
                            window_left = '0;
                            click       = bcc_pkg::EV_DOUBLE;
                        end
                    end
                end
            end
        end
        res.click_event  = click;
        res.stable_level = level_now;
        return res;
    endfunction

    task automatic send_tick(input logic level);
        int unsigned gap;
        bcc_pkg::bcc_result_t res;
        gap = idle_draw(tick_idle);
        if (gap != 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_bus.valid        <= 1'b1;
        tick_bus.button_level <= level;
        do @(posedge clk); while (!tick_bus.ready);
        res = classify_tick(level);
        pending_results.push_back(res);
        click_count[res.click_event]++;
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int unsigned n);
        repeat (n) send_tick(level);
    endtask

    task automatic wait_idle();
        tick_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bcc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bcc_pkg::CFG_DATA_W-1:0] value, input bit last);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        if (last)
            cfg_bus.valid <= 1'b0;
        case (idx)
            bcc_pkg::REG_DEBOUNCE: set_debounce = value[bcc_pkg::DEB_W-1:0];
            bcc_pkg::REG_LONG:     set_long = value;
            bcc_pkg::REG_DOUBLE:   set_double = value;
            default:               ;
        endcase
        writes_done++;
    endtask

    task automatic set_config(input logic [bcc_pkg::CFG_DATA_W-1:0] deb,
                              input logic [bcc_pkg::CFG_DATA_W-1:0] lng,
                              input logic [bcc_pkg::CFG_DATA_W-1:0] dbl);
        wait_idle();
        write_reg(bcc_pkg::REG_DEBOUNCE, deb, 1'b0);
        write_reg(bcc_pkg::REG_LONG, lng, 1'b0);
        write_reg(bcc_pkg::REG_DOUBLE, dbl, 1'b1);
    endtask

    // result side: random stall before each request
    initial
    begin
        int unsigned stall;
        click_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_draw(sink_idle);
            if (stall != 0)
            begin
                click_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            click_bus.ready <= 1'b1;
            do @(posedge clk); while (!click_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        bcc_pkg::bcc_result_t want;
        if (rst_n && click_bus.valid && click_bus.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual event %0d level %0b",
                         $time, click_bus.click_event, click_bus.stable_level);
            end
            else
            begin
                want = pending_results.pop_front();
                if (click_bus.click_event !== want.click_event)
                begin
                    errors++;
                    $display("%0t: click_event mismatch: expected %0d, actual %0d",
                             $time, want.click_event, click_bus.click_event);
                end
                if (click_bus.stable_level !== want.stable_level)
                begin
                    errors++;
                    $display("%0t: stable_level mismatch: expected %0b, actual %0b",
                             $time, want.stable_level, click_bus.stable_level);
                end
            end
        end
    end

    // glitch that settles back at the stable level, default settings
    task automatic test_power_on_defaults();
        send_tick(1'b1);
        send_run(1'b0, 6);
    endtask

    task automatic test_single_click();
        set_config(16'hAB01, 16'd4, 16'd6);
        send_run(1'b1, 2);
        send_run(1'b0, 8);
    endtask

    task automatic test_double_click();
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
    endtask

    task automatic test_long_click();
        send_run(1'b1, 6);
        send_run(1'b0, 2);
    endtask

    task automatic test_long_clears_window();
        set_config(16'd1, 16'd4, 16'd20);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 6);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
    endtask

    // zero settings act as one; the spare index is ignored
    task automatic test_zero_settings();
        set_config(16'd0, 16'd0, 16'd0);
        write_reg(REG_SPARE, 16'h5A5A, 1'b1);
        send_run(1'b1, 4);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 3);
    endtask

    // debounce upper byte dropped, full-range hold and window
    task automatic test_extreme_settings();
        tick_idle = 1'b0;
        set_config(16'hFF00, 16'hFFFF, 16'hFFFF);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        tick_idle = 1'b1;
    endtask

    // mostly press/release sequences with bounce, some pure noise
    task automatic test_random_clicks();
        int unsigned deb;
        int unsigned lng;
        int unsigned dbl;
        int unsigned phase_start;
        int unsigned pick;
        for (int phase = 0; phase < 6; phase++)
        begin
            deb = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(4, 1);
            lng = $urandom_range(40, 2);
            dbl = $urandom_range(30, 2);
            set_config(bcc_pkg::CFG_DATA_W'(deb), bcc_pkg::CFG_DATA_W'(lng),
                       bcc_pkg::CFG_DATA_W'(dbl));
            tick_idle   = $urandom_range(1, 0);
            sink_idle   = $urandom_range(1, 0);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < 40)
            begin
                pick = $urandom_range(9, 0);
                if (pick == 0)
                    repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1, 0)));
                else
                begin
                    repeat ($urandom_range(2, 0)) send_tick(1'($urandom_range(1, 0)));
                    send_run(1'b1, $urandom_range(deb + lng + 4, deb + 1));
                    repeat ($urandom_range(2, 0)) send_tick(1'($urandom_range(1, 0)));
                    send_run(1'b0, $urandom_range(deb + dbl + 4, deb + 1));
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        tick_bus.valid        <= 1'b0;
        tick_bus.button_level <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= bcc_pkg::REG_DEBOUNCE;
        cfg_bus.data          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_single_click();
        test_double_click();
        test_long_click();
        test_long_clears_window();
        test_zero_settings();
        test_extreme_settings();
        test_random_clicks();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("sent %0d ticks with %0d register writes, checked %0d results",
                 ticks_sent, writes_done, results_seen);
        $display("clicks seen: %0d single, %0d double, %0d long",
                 click_count[bcc_pkg::EV_SINGLE], click_count[bcc_pkg::EV_DOUBLE],
                 click_count[bcc_pkg::EV_LONG]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #500_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
src/bcc_pkg.sv
src/bcc_ifs.sv
src/bcc_core.sv
src/bcc_queue.sv
src/button_click_classifier_unit.sv
verif/button_click_classifier_unit_test.sv
